// ----- rtl/z80ilc_pkg.sv -----
package z80ilc_pkg;

   localparam int unsigned AddrWidth = 16;
   localparam int unsigned ByteWidth = 8;
   localparam int unsigned LeftWidth = 2;
   localparam int unsigned LenWidth  = 3;
   localparam int unsigned KindWidth = 5;
   localparam int unsigned RegWidth  = 3;
   localparam int unsigned WordWidth = 16;

   localparam logic [ByteWidth-1:0] OP_CB = 8'hCB;
   localparam logic [ByteWidth-1:0] OP_ED = 8'hED;
   localparam logic [ByteWidth-1:0] OP_DD = 8'hDD;
   localparam logic [ByteWidth-1:0] OP_FD = 8'hFD;
   localparam logic [ByteWidth-1:0] OP_HALT = 8'h76;
   localparam logic [ByteWidth-1:0] OP_LD_A_HL = 8'h7E;
   localparam logic [ByteWidth-1:0] MASK_XYZ = 8'hC7;
   localparam logic [ByteWidth-1:0] ED_LD_NN_RR = 8'h43;
   localparam logic [ByteWidth-1:0] ED_OUT_C_R = 8'h41;
   localparam logic [ByteWidth-1:0] ED_IN_R_C = 8'h40;
   localparam logic [ByteWidth-1:0] MASK_Y = 8'h38;
   localparam logic [ByteWidth-1:0] Y_HL_IND = 8'h30;

   localparam logic [RegWidth-1:0] REG_HL_IND = 3'd6;
   localparam logic [RegWidth-1:0] REG_A = 3'd7;

   localparam logic [KindWidth-1:0] KIND_OTHER    = 5'd0;
   localparam logic [KindWidth-1:0] KIND_OUT_N_A  = 5'd1;
   localparam logic [KindWidth-1:0] KIND_IN_A_N   = 5'd2;
   localparam logic [KindWidth-1:0] KIND_LD_A_IMM = 5'd3;
   localparam logic [KindWidth-1:0] KIND_LD_B_IMM = 5'd4;
   localparam logic [KindWidth-1:0] KIND_LD_A_REG = 5'd10;
   localparam logic [KindWidth-1:0] KIND_LD_A_MEM = 5'd11;
   localparam logic [KindWidth-1:0] KIND_CALL     = 5'd12;
   localparam logic [KindWidth-1:0] KIND_CALL_CC  = 5'd13;
   localparam logic [KindWidth-1:0] KIND_RET      = 5'd14;
   localparam logic [KindWidth-1:0] KIND_RET_CC   = 5'd15;
   localparam logic [KindWidth-1:0] KIND_JP       = 5'd16;
   localparam logic [KindWidth-1:0] KIND_JP_CC    = 5'd17;
   localparam logic [KindWidth-1:0] KIND_JR       = 5'd18;
   localparam logic [KindWidth-1:0] KIND_JR_CC    = 5'd19;
   localparam logic [KindWidth-1:0] KIND_LD_HL_NN = 5'd20;
   localparam logic [KindWidth-1:0] KIND_LD_DE_NN = 5'd21;
   localparam logic [KindWidth-1:0] KIND_RST      = 5'd22;
   localparam logic [KindWidth-1:0] KIND_LD_R_R   = 5'd23;
   localparam logic [KindWidth-1:0] KIND_LD_MEM_A = 5'd24;
   localparam logic [KindWidth-1:0] KIND_OUT_C_R  = 5'd25;
   localparam logic [KindWidth-1:0] KIND_IN_R_C   = 5'd26;
   localparam logic [KindWidth-1:0] KIND_INC_R    = 5'd27;
   localparam logic [KindWidth-1:0] KIND_DEC_R    = 5'd28;

   localparam logic [1:0] PLAIN_LEN [256] = '{
      2'd1,2'd3,2'd1,2'd1,2'd1,2'd1,2'd2,2'd1,2'd1,2'd1,2'd1,2'd1,2'd1,2'd1,2'd2,2'd1,
      2'd2,2'd3,2'd1,2'd1,2'd1,2'd1,2'd2,2'd1,2'd2,2'd1,2'd1,2'd1,2'd1,2'd1,2'd2,2'd1,
      2'd2,2'd3,2'd3,2'd1,2'd1,2'd1,2'd2,2'd1,2'd2,2'd1,2'd3,2'd1,2'd1,2'd1,2'd2,2'd1,
      2'd2,2'd3,2'd3,2'd1,2'd1,2'd1,2'd2,2'd1,2'd2,2'd1,2'd3,2'd1,2'd1,2'd1,2'd2,2'd1,
      2'd1,2'd1,2'd1,2'd1,2'd1,2'd1,2'd1,2'd1,2'd1,2'd1,2'd1,2'd1,2'd1,2'd1,2'd1,2'd1,
      2'd1,2'd1,2'd1,2'd1,2'd1,2'd1,2'd1,2'd1,2'd1,2'd1,2'd1,2'd1,2'd1,2'd1,2'd1,2'd1,
      2'd1,2'd1,2'd1,2'd1,2'd1,2'd1,2'd1,2'd1,2'd1,2'd1,2'd1,2'd1,2'd1,2'd1,2'd1,2'd1,
      2'd1,2'd1,2'd1,2'd1,2'd1,2'd1,2'd1,2'd1,2'd1,2'd1,2'd1,2'd1,2'd1,2'd1,2'd1,2'd1,
      2'd1,2'd1,2'd1,2'd1,2'd1,2'd1,2'd1,2'd1,2'd1,2'd1,2'd1,2'd1,2'd1,2'd1,2'd1,2'd1,
      2'd1,2'd1,2'd1,2'd1,2'd1,2'd1,2'd1,2'd1,2'd1,2'd1,2'd1,2'd1,2'd1,2'd1,2'd1,2'd1,
      2'd1,2'd1,2'd1,2'd1,2'd1,2'd1,2'd1,2'd1,2'd1,2'd1,2'd1,2'd1,2'd1,2'd1,2'd1,2'd1,
      2'd1,2'd1,2'd1,2'd1,2'd1,2'd1,2'd1,2'd1,2'd1,2'd1,2'd1,2'd1,2'd1,2'd1,2'd1,2'd1,
      2'd1,2'd1,2'd3,2'd3,2'd3,2'd1,2'd2,2'd1,2'd1,2'd1,2'd3,2'd0,2'd3,2'd3,2'd2,2'd1,
      2'd1,2'd1,2'd3,2'd2,2'd3,2'd1,2'd2,2'd1,2'd1,2'd1,2'd3,2'd2,2'd3,2'd0,2'd2,2'd1,
      2'd1,2'd1,2'd3,2'd1,2'd3,2'd1,2'd2,2'd1,2'd1,2'd1,2'd3,2'd1,2'd3,2'd0,2'd2,2'd1,
      2'd1,2'd1,2'd3,2'd1,2'd3,2'd1,2'd2,2'd1,2'd1,2'd1,2'd3,2'd1,2'd3,2'd0,2'd2,2'd1
   };

   typedef struct packed {
      logic [LenWidth-1:0]  len;
      logic [KindWidth-1:0] kind;
      logic [RegWidth-1:0]  src;
      logic [RegWidth-1:0]  dst;
      logic [ByteWidth-1:0] imm8;
      logic [WordWidth-1:0] imm16;
   } decode_type;

endpackage

// ----- rtl/z80ilc_decode.sv -----
module z80ilc_decode
   import z80ilc_pkg::*;
(
   input  logic [ByteWidth-1:0] first_byte,
   input  logic [ByteWidth-1:0] second_byte,
   input  logic [ByteWidth-1:0] third_byte,
   input  logic [LeftWidth-1:0] bytes_left,
   output decode_type           result
);

   logic                 has8;
   logic                 has16;
   logic [RegWidth-1:0]  r;
   logic [RegWidth-1:0]  s;
   logic [WordWidth-1:0] word;
   logic [LenWidth-1:0]  plain;
   logic [LenWidth-1:0]  idx_len;
   logic                 disp;
   logic [ByteWidth-1:0] op;
   logic [ByteWidth-1:0] b1;

   assign op    = first_byte;
   assign b1    = second_byte;
   assign has8  = bytes_left >= 2'd2;
   assign has16 = bytes_left == 2'd3;
   assign r     = op[5:3];
   assign s     = op[2:0];
   assign word  = {third_byte, second_byte};
   assign plain = {1'b0, PLAIN_LEN[op]};

   always_comb begin
      disp = 1'b0;
      if (b1[7:6] == 2'b01) begin
         if (b1 != OP_HALT) begin
            disp = (b1[2:0] == REG_HL_IND) || ((b1 & MASK_Y) == Y_HL_IND);
         end
      end else if (b1[7:6] == 2'b10) begin
         disp = b1[2:0] == REG_HL_IND;
      end else if (b1 == 8'h34 || b1 == 8'h35 || b1 == 8'h36) begin
         disp = 1'b1;
      end
      if (b1 == OP_CB) begin
         idx_len = 3'd4;
      end else if (b1 == OP_DD || b1 == OP_FD || b1 == OP_ED) begin
         idx_len = 3'd1;
      end else begin
         idx_len = 3'd1 + {1'b0, PLAIN_LEN[b1]} + {2'b00, disp};
      end
   end

   always_comb begin
      result = '0;
      if (bytes_left == 2'd0) begin
         result = '0;
      end else if (op == OP_CB) begin
         result.len = 3'd2;
      end else if (op == OP_ED) begin
         if (!has8) begin
            result.len = 3'd1;
         end else begin
            result.len = ((b1 & MASK_XYZ) == ED_LD_NN_RR) ? 3'd4 : 3'd2;
            if ((b1 & MASK_XYZ) == ED_OUT_C_R) begin
               result.kind = KIND_OUT_C_R;
               result.src  = b1[5:3];
            end else if ((b1 & MASK_XYZ) == ED_IN_R_C) begin
               result.kind = KIND_IN_R_C;
               result.dst  = b1[5:3];
            end
         end
      end else if (op == OP_DD || op == OP_FD) begin
         result.len = has8 ? idx_len : 3'd1;
         if (has16 && b1 == OP_LD_A_HL) begin
            result.kind = KIND_LD_A_MEM;
            result.len  = 3'd3;
         end
      end else begin
         result.len = plain;
         if (op == 8'hD3) begin
            result.kind = KIND_OUT_N_A;
            result.imm8 = has8 ? b1 : '0;
         end else if (op == 8'hDB) begin
            result.kind = KIND_IN_A_N;
            result.imm8 = has8 ? b1 : '0;
         end else if (op == 8'h3E) begin
            result.kind = KIND_LD_A_IMM;
            result.imm8 = has8 ? b1 : '0;
         end else if ((op & MASK_XYZ) == 8'h06 && r != REG_HL_IND) begin
            result.kind = KIND_LD_B_IMM + {2'b00, r};
            result.imm8 = has8 ? b1 : '0;
         end else if (op[7:3] == 5'b01111 && op != OP_LD_A_HL) begin
            result.kind = KIND_LD_A_REG;
            result.src  = s;
            result.dst  = REG_A;
         end else if (op == OP_LD_A_HL || op == 8'h0A || op == 8'h1A) begin
            result.kind = KIND_LD_A_MEM;
         end else if (op == 8'h3A) begin
            result.kind  = KIND_LD_A_MEM;
            result.imm16 = has16 ? word : '0;
         end else if (op == 8'h32) begin
            result.kind  = KIND_LD_MEM_A;
            result.imm16 = has16 ? word : '0;
         end else if (op == 8'h11) begin
            result.kind  = KIND_LD_DE_NN;
            result.imm16 = has16 ? word : '0;
         end else if (op == 8'h21) begin
            result.kind  = KIND_LD_HL_NN;
            result.imm16 = has16 ? word : '0;
         end else if ((op & MASK_XYZ) == 8'h04 && r != REG_HL_IND) begin
            result.kind = KIND_INC_R;
            result.dst  = r;
         end else if ((op & MASK_XYZ) == 8'h05 && r != REG_HL_IND) begin
            result.kind = KIND_DEC_R;
            result.dst  = r;
         end else if ((op & MASK_XYZ) == MASK_XYZ) begin
            result.kind = KIND_RST;
            result.imm8 = op & MASK_Y;
         end else if (op == 8'hCD) begin
            result.kind  = KIND_CALL;
            result.imm16 = has16 ? word : '0;
         end else if ((op & MASK_XYZ) == 8'hC4) begin
            result.kind  = KIND_CALL_CC;
            result.imm16 = has16 ? word : '0;
         end else if (op == 8'hC9) begin
            result.kind = KIND_RET;
         end else if ((op & MASK_XYZ) == 8'hC0) begin
            result.kind = KIND_RET_CC;
         end else if (op == 8'hC3) begin
            result.kind  = KIND_JP;
            result.imm16 = has16 ? word : '0;
         end else if ((op & MASK_XYZ) == 8'hC2) begin
            result.kind  = KIND_JP_CC;
            result.imm16 = has16 ? word : '0;
         end else if (op == 8'h18) begin
            result.kind = KIND_JR;
            result.imm8 = has8 ? b1 : '0;
         end else if (op == 8'h20 || op == 8'h28 || op == 8'h30 || op == 8'h38) begin
            result.kind = KIND_JR_CC;
            result.imm8 = has8 ? b1 : '0;
         end else if (op[7:6] == 2'b01 && s != REG_HL_IND && r != REG_HL_IND) begin
            result.kind = KIND_LD_R_R;
            result.dst  = r;
            result.src  = s;
         end
      end
   end

endmodule

// ----- rtl/z80_instruction_length_classifier.sv -----
// Z80 instruction length and kind classifier.
// The start beat is registered into the request stage, decoded, and then
// registered into the result stage that drives the result strobe.
// Throughput: one beat per cycle; busy stays low, so start is taken every cycle.
// Reset clears both stage valid flags; payload registers are not reset.
// The receiver cannot stall: each result is on rsp_ for one cycle only.
module z80_instruction_length_classifier
   import z80ilc_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  logic [AddrWidth-1:0] req_code_address,
   input  logic [ByteWidth-1:0] req_first_byte,
   input  logic [ByteWidth-1:0] req_second_byte,
   input  logic [ByteWidth-1:0] req_third_byte,
   input  logic [LeftWidth-1:0] req_bytes_left,
   output logic                 rsp_strobe,
   output logic [LenWidth-1:0]  rsp_insn_length,
   output logic [KindWidth-1:0] rsp_insn_kind,
   output logic [RegWidth-1:0]  rsp_source_register,
   output logic [RegWidth-1:0]  rsp_dest_register,
   output logic [ByteWidth-1:0] rsp_immediate_byte,
   output logic [WordWidth-1:0] rsp_immediate_word,
   output logic [AddrWidth-1:0] rsp_insn_address
);

   logic                 req_valid_ff;
   logic [AddrWidth-1:0] req_addr_ff;
   logic [ByteWidth-1:0] req_b0_ff;
   logic [ByteWidth-1:0] req_b1_ff;
   logic [ByteWidth-1:0] req_b2_ff;
   logic [LeftWidth-1:0] req_left_ff;
   logic                 rsp_valid_ff;
   decode_type           rsp_dec_ff;
   logic [AddrWidth-1:0] rsp_addr_ff;
   decode_type           rsp_dec_in;

   assign busy = 1'b0;

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         req_valid_ff <= start && !busy;
         rsp_valid_ff <= req_valid_ff;
      end
      req_addr_ff <= req_code_address;
      req_b0_ff   <= req_first_byte;
      req_b1_ff   <= req_second_byte;
      req_b2_ff   <= req_third_byte;
      req_left_ff <= req_bytes_left;
      rsp_dec_ff  <= rsp_dec_in;
      rsp_addr_ff <= req_addr_ff;
   end

   z80ilc_decode u_decode (
      .first_byte  (req_b0_ff),
      .second_byte (req_b1_ff),
      .third_byte  (req_b2_ff),
      .bytes_left  (req_left_ff),
      .result      (rsp_dec_in)
   );

   assign rsp_strobe          = rsp_valid_ff;
   assign rsp_insn_length     = rsp_dec_ff.len;
   assign rsp_insn_kind       = rsp_dec_ff.kind;
   assign rsp_source_register = rsp_dec_ff.src;
   assign rsp_dest_register   = rsp_dec_ff.dst;
   assign rsp_immediate_byte  = rsp_dec_ff.imm8;
   assign rsp_immediate_word  = rsp_dec_ff.imm16;
   assign rsp_insn_address    = rsp_addr_ff;

   a_strobe_follows_start: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(start && !busy, 2))
      else $error("result strobe without a start beat two cycles earlier");

   a_address_echo: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> rsp_insn_address == $past(req_code_address, 2))
      else $error("result address does not match the start beat");

   a_zero_len_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> ((rsp_insn_length == 3'd0) == ($past(req_bytes_left, 2) == 2'd0)))
      else $error("zero length does not match an empty window");

   a_len_range: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> rsp_insn_length <= 3'd4 && rsp_insn_kind <= KIND_DEC_R)
      else $error("length or kind out of range");

endmodule

// ----- bench/testbench.sv -----
module testbench;
   import z80ilc_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [ByteWidth-1:0] OPC_LD_A_BC  = 8'h0A;
   localparam logic [ByteWidth-1:0] OPC_DJNZ     = 8'h10;
   localparam logic [ByteWidth-1:0] OPC_LD_DE_NN = 8'h11;
   localparam logic [ByteWidth-1:0] OPC_JR       = 8'h18;
   localparam logic [ByteWidth-1:0] OPC_LD_A_DE  = 8'h1A;
   localparam logic [ByteWidth-1:0] OPC_JR_NZ    = 8'h20;
   localparam logic [ByteWidth-1:0] OPC_LD_HL_NN = 8'h21;
   localparam logic [ByteWidth-1:0] OPC_LD_NN_HL = 8'h22;
   localparam logic [ByteWidth-1:0] OPC_JR_Z     = 8'h28;
   localparam logic [ByteWidth-1:0] OPC_LD_HL_MM = 8'h2A;
   localparam logic [ByteWidth-1:0] OPC_JR_NC    = 8'h30;
   localparam logic [ByteWidth-1:0] OPC_LD_NN_A  = 8'h32;
   localparam logic [ByteWidth-1:0] OPC_INC_IHL  = 8'h34;
   localparam logic [ByteWidth-1:0] OPC_DEC_IHL  = 8'h35;
   localparam logic [ByteWidth-1:0] OPC_LD_IHL_N = 8'h36;
   localparam logic [ByteWidth-1:0] OPC_JR_C     = 8'h38;
   localparam logic [ByteWidth-1:0] OPC_LD_A_NN  = 8'h3A;
   localparam logic [ByteWidth-1:0] OPC_LD_A_N   = 8'h3E;
   localparam logic [ByteWidth-1:0] OPC_LD_A_B   = 8'h78;
   localparam logic [ByteWidth-1:0] OPC_LD_A_C   = 8'h79;
   localparam logic [ByteWidth-1:0] OPC_JP       = 8'hC3;
   localparam logic [ByteWidth-1:0] OPC_RET      = 8'hC9;
   localparam logic [ByteWidth-1:0] OPC_CALL     = 8'hCD;
   localparam logic [ByteWidth-1:0] OPC_OUT_N_A  = 8'hD3;
   localparam logic [ByteWidth-1:0] OPC_IN_A_N   = 8'hDB;
   localparam logic [ByteWidth-1:0] OPC_RST_38   = 8'hFF;
   localparam logic [ByteWidth-1:0] PAT_INC_R    = 8'h04;
   localparam logic [ByteWidth-1:0] PAT_DEC_R    = 8'h05;
   localparam logic [ByteWidth-1:0] PAT_LD_R_N   = 8'h06;
   localparam logic [ByteWidth-1:0] PAT_RET_CC   = 8'hC0;
   localparam logic [ByteWidth-1:0] PAT_JP_CC    = 8'hC2;
   localparam logic [ByteWidth-1:0] PAT_CALL_CC  = 8'hC4;
   localparam logic [ByteWidth-1:0] PAT_RST      = 8'hC7;

   localparam int unsigned RandomBeats = 450;

   typedef struct packed {
      logic [LenWidth-1:0]  len;
      logic [KindWidth-1:0] kind;
      logic [RegWidth-1:0]  src;
      logic [RegWidth-1:0]  dst;
      logic [ByteWidth-1:0] imm8;
      logic [WordWidth-1:0] imm16;
      logic [AddrWidth-1:0] addr;
   } insn_decode_t;

   typedef struct {
      logic [AddrWidth-1:0] addr;
      logic [ByteWidth-1:0] op;
      logic [ByteWidth-1:0] b1;
      logic [ByteWidth-1:0] b2;
      logic [LeftWidth-1:0] left;
      logic                 typed;
      insn_decode_t         want;
   } stim_row_t;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 start = 1'b0;
   logic                 busy;
   logic [AddrWidth-1:0] req_code_address = '0;
   logic [ByteWidth-1:0] req_first_byte = '0;
   logic [ByteWidth-1:0] req_second_byte = '0;
   logic [ByteWidth-1:0] req_third_byte = '0;
   logic [LeftWidth-1:0] req_bytes_left = '0;
   logic                 rsp_strobe;
   logic [LenWidth-1:0]  rsp_insn_length;
   logic [KindWidth-1:0] rsp_insn_kind;
   logic [RegWidth-1:0]  rsp_source_register;
   logic [RegWidth-1:0]  rsp_dest_register;
   logic [ByteWidth-1:0] rsp_immediate_byte;
   logic [WordWidth-1:0] rsp_immediate_word;
   logic [AddrWidth-1:0] rsp_insn_address;

   logic                 beat_typed = 1'b0;
   insn_decode_t         beat_typed_want = '0;
   insn_decode_t         pending_decodes[$];
   int unsigned          fault_count = 0;

   z80_instruction_length_classifier dut (
      .clock               (clock),
      .reset               (reset),
      .start               (start),
      .busy                (busy),
      .req_code_address    (req_code_address),
      .req_first_byte      (req_first_byte),
      .req_second_byte     (req_second_byte),
      .req_third_byte      (req_third_byte),
      .req_bytes_left      (req_bytes_left),
      .rsp_strobe          (rsp_strobe),
      .rsp_insn_length     (rsp_insn_length),
      .rsp_insn_kind       (rsp_insn_kind),
      .rsp_source_register (rsp_source_register),
      .rsp_dest_register   (rsp_dest_register),
      .rsp_immediate_byte  (rsp_immediate_byte),
      .rsp_immediate_word  (rsp_immediate_word),
      .rsp_insn_address    (rsp_insn_address)
   );

   always #5 clock = ~clock;

   function automatic logic [LenWidth-1:0] base_length(logic [ByteWidth-1:0] op);
      if (op inside {OP_CB, OP_DD, OP_ED, OP_FD}) return 3'd0;
      if (op[7:6] == 2'b00) begin
         if (op[2:0] == REG_HL_IND ||
             op inside {OPC_DJNZ, OPC_JR, OPC_JR_NZ, OPC_JR_Z, OPC_JR_NC, OPC_JR_C})
            return 3'd2;
         if (op[3:0] == 4'h1 ||
             op inside {OPC_LD_NN_HL, OPC_LD_HL_MM, OPC_LD_NN_A, OPC_LD_A_NN})
            return 3'd3;
         return 3'd1;
      end
      if (op[7:6] == 2'b11) begin
         if (op[2:0] == REG_HL_IND || op inside {OPC_OUT_N_A, OPC_IN_A_N}) return 3'd2;
         if (op[2:0] == 3'd2 || op[2:0] == 3'd4 || op inside {OPC_JP, OPC_CALL})
            return 3'd3;
      end
      return 3'd1;
   endfunction

   // length of a DD/FD form; a (HL) operand gains a displacement byte
   function automatic logic [LenWidth-1:0] index_length(logic [ByteWidth-1:0] op);
      logic disp;
      disp = 1'b0;
      if (op == OP_CB) return 3'd4;
      if (op inside {OP_DD, OP_FD, OP_ED}) return 3'd1;
      if (op[7:6] == 2'b01)
         disp = op != OP_HALT && (op[2:0] == REG_HL_IND || op[5:3] == REG_HL_IND);
      else if (op[7:6] == 2'b10)
         disp = op[2:0] == REG_HL_IND;
      else if (op inside {OPC_INC_IHL, OPC_DEC_IHL, OPC_LD_IHL_N})
         disp = 1'b1;
      return 3'd1 + base_length(op) + {2'b00, disp};
   endfunction

   function automatic insn_decode_t classify_insn(logic [AddrWidth-1:0] addr,
                                                  logic [ByteWidth-1:0] op,
                                                  logic [ByteWidth-1:0] b1,
                                                  logic [ByteWidth-1:0] b2,
                                                  logic [LeftWidth-1:0] left);
      insn_decode_t         d;
      logic                 has8;
      logic                 has16;
      logic [WordWidth-1:0] word;
      logic [RegWidth-1:0]  r;
      logic [RegWidth-1:0]  s;
      d = '0;
      d.addr = addr;
      has8 = left >= 2'd2;
      has16 = left == 2'd3;
      word = {b2, b1};
      r = op[5:3];
      s = op[2:0];
      if (left != 2'd0) begin
         if (op == OP_CB) begin
            d.len = 3'd2;
         end else if (op == OP_ED) begin
            if (!has8) begin
               d.len = 3'd1;
            end else begin
               d.len = ((b1 & MASK_XYZ) == ED_LD_NN_RR) ? 3'd4 : 3'd2;
               if ((b1 & MASK_XYZ) == ED_OUT_C_R) begin
                  d.kind = KIND_OUT_C_R;
                  d.src = b1[5:3];
               end else if ((b1 & MASK_XYZ) == ED_IN_R_C) begin
                  d.kind = KIND_IN_R_C;
                  d.dst = b1[5:3];
               end
            end
         end else if (op == OP_DD || op == OP_FD) begin
            d.len = has8 ? index_length(b1) : 3'd1;
            if (has16 && b1 == OP_LD_A_HL) begin
               d.kind = KIND_LD_A_MEM;
               d.len = 3'd3;
            end
         end else begin
            d.len = base_length(op);
            if (op == OPC_OUT_N_A) begin
               d.kind = KIND_OUT_N_A;
               if (has8) d.imm8 = b1;
            end else if (op == OPC_IN_A_N) begin
               d.kind = KIND_IN_A_N;
               if (has8) d.imm8 = b1;
            end else if (op == OPC_LD_A_N) begin
               d.kind = KIND_LD_A_IMM;
               if (has8) d.imm8 = b1;
            end else if ((op & MASK_XYZ) == PAT_LD_R_N && r != REG_HL_IND) begin
               d.kind = KIND_LD_B_IMM + {2'b00, r};
               if (has8) d.imm8 = b1;
            end else if (op[7:3] == 5'b01111 && op != OP_LD_A_HL) begin
               d.kind = KIND_LD_A_REG;
               d.src = s;
               d.dst = REG_A;
            end else if (op inside {OP_LD_A_HL, OPC_LD_A_BC, OPC_LD_A_DE}) begin
               d.kind = KIND_LD_A_MEM;
            end else if (op == OPC_LD_A_NN) begin
               d.kind = KIND_LD_A_MEM;
               if (has16) d.imm16 = word;
            end else if (op == OPC_LD_NN_A) begin
               d.kind = KIND_LD_MEM_A;
               if (has16) d.imm16 = word;
            end else if (op == OPC_LD_DE_NN) begin
               d.kind = KIND_LD_DE_NN;
               if (has16) d.imm16 = word;
            end else if (op == OPC_LD_HL_NN) begin
               d.kind = KIND_LD_HL_NN;
               if (has16) d.imm16 = word;
            end else if ((op & MASK_XYZ) == PAT_INC_R && r != REG_HL_IND) begin
               d.kind = KIND_INC_R;
               d.dst = r;
            end else if ((op & MASK_XYZ) == PAT_DEC_R && r != REG_HL_IND) begin
               d.kind = KIND_DEC_R;
               d.dst = r;
            end else if ((op & MASK_XYZ) == PAT_RST) begin
               d.kind = KIND_RST;
               d.imm8 = op & MASK_Y;
            end else if (op == OPC_CALL) begin
               d.kind = KIND_CALL;
               if (has16) d.imm16 = word;
            end else if ((op & MASK_XYZ) == PAT_CALL_CC) begin
               d.kind = KIND_CALL_CC;
               if (has16) d.imm16 = word;
            end else if (op == OPC_RET) begin
               d.kind = KIND_RET;
            end else if ((op & MASK_XYZ) == PAT_RET_CC) begin
               d.kind = KIND_RET_CC;
            end else if (op == OPC_JP) begin
               d.kind = KIND_JP;
               if (has16) d.imm16 = word;
            end else if ((op & MASK_XYZ) == PAT_JP_CC) begin
               d.kind = KIND_JP_CC;
               if (has16) d.imm16 = word;
            end else if (op == OPC_JR) begin
               d.kind = KIND_JR;
               if (has8) d.imm8 = b1;
            end else if (op inside {OPC_JR_NZ, OPC_JR_Z, OPC_JR_NC, OPC_JR_C}) begin
               d.kind = KIND_JR_CC;
               if (has8) d.imm8 = b1;
            end else if (op[7:6] == 2'b01 && s != REG_HL_IND && r != REG_HL_IND) begin
               d.kind = KIND_LD_R_R;
               d.dst = r;
               d.src = s;
            end
         end
      end
      return d;
   endfunction

   function automatic stim_row_t plain_row(logic [AddrWidth-1:0] addr,
                                           logic [ByteWidth-1:0] op,
                                           logic [ByteWidth-1:0] b1,
                                           logic [ByteWidth-1:0] b2,
                                           logic [LeftWidth-1:0] left);
      stim_row_t row;
      row.addr = addr;
      row.op = op;
      row.b1 = b1;
      row.b2 = b2;
      row.left = left;
      row.typed = 1'b0;
      row.want = '0;
      return row;
   endfunction

   function automatic stim_row_t typed_row(logic [AddrWidth-1:0] addr,
                                           logic [ByteWidth-1:0] op,
                                           logic [ByteWidth-1:0] b1,
                                           logic [ByteWidth-1:0] b2,
                                           logic [LeftWidth-1:0] left,
                                           logic [LenWidth-1:0]  len,
                                           logic [KindWidth-1:0] kind);
      stim_row_t row;
      row = plain_row(addr, op, b1, b2, left);
      row.typed = 1'b1;
      row.want.len = len;
      row.want.kind = kind;
      row.want.addr = addr;
      return row;
   endfunction

   task automatic check_field(string name, logic [15:0] want, logic [15:0] got);
      if (got !== want) begin
         $error("%s expected %0h actual %0h", name, want, got);
         fault_count++;
      end
   endtask

   task automatic send_beat(stim_row_t row);
      start <= 1'b1;
      req_code_address <= row.addr;
      req_first_byte <= row.op;
      req_second_byte <= row.b1;
      req_third_byte <= row.b2;
      req_bytes_left <= row.left;
      beat_typed <= row.typed;
      beat_typed_want <= row.want;
      do @(posedge clock); while (busy !== 1'b0);
   endtask

   task automatic idle_gap(logic quiet);
      while (!quiet && $urandom_range(99) < 19) begin
         start <= 1'b0;
         @(posedge clock);
      end
   endtask

   always @(posedge clock) begin
      insn_decode_t want;
      if (!reset) begin
         if (rsp_strobe === 1'b1) begin
            if (pending_decodes.size() == 0) begin
               $error("unexpected result at insn_address %0h", rsp_insn_address);
               fault_count++;
            end else begin
               want = pending_decodes.pop_front();
               check_field("insn_length", 16'(want.len), 16'(rsp_insn_length));
               check_field("insn_kind", 16'(want.kind), 16'(rsp_insn_kind));
               check_field("source_register", 16'(want.src), 16'(rsp_source_register));
               check_field("dest_register", 16'(want.dst), 16'(rsp_dest_register));
               check_field("immediate_byte", 16'(want.imm8), 16'(rsp_immediate_byte));
               check_field("immediate_word", want.imm16, rsp_immediate_word);
               check_field("insn_address", want.addr, rsp_insn_address);
            end
         end
         if (start && !busy)
            pending_decodes.push_back(beat_typed ? beat_typed_want :
               classify_insn(req_code_address, req_first_byte, req_second_byte,
                             req_third_byte, req_bytes_left));
      end
   end

   initial begin
      stim_row_t            directed_rows[$];
      stim_row_t            row;
      logic [RegWidth-1:0]  fld;
      logic                 quiet;
      directed_rows = '{
         typed_row(16'h0000, OPC_LD_A_N, 8'hFF, 8'hFF, 2'd0, 3'd0, KIND_OTHER),
         typed_row(16'hFFFF, 8'hFF, 8'hFF, 8'hFF, 2'd0, 3'd0, KIND_OTHER),
         typed_row(16'h1234, OP_CB, 8'h00, 8'h00, 2'd1, 3'd2, KIND_OTHER),
         typed_row(16'hFFFF, OP_CB, 8'hFF, 8'hFF, 2'd3, 3'd2, KIND_OTHER),
         typed_row(16'h8000, OP_ED, ED_LD_NN_RR, 8'h00, 2'd1, 3'd1, KIND_OTHER),
         typed_row(16'h0001, OP_DD, OP_LD_A_HL, 8'h55, 2'd1, 3'd1, KIND_OTHER),
         typed_row(16'h4000, OP_FD, OP_DD, 8'h00, 2'd3, 3'd1, KIND_OTHER),
         typed_row(16'h4001, OP_DD, OP_FD, 8'hAA, 2'd3, 3'd1, KIND_OTHER),
         typed_row(16'h4002, OP_DD, OP_ED, 8'h43, 2'd2, 3'd1, KIND_OTHER),
         typed_row(16'h4003, OP_FD, OP_CB, 8'h06, 2'd3, 3'd4, KIND_OTHER),
         typed_row(16'h4004, OP_DD, OP_LD_A_HL, 8'h7F, 2'd2, 3'd3, KIND_OTHER),
         plain_row(16'h5000, OP_ED, ED_LD_NN_RR, 8'hFF, 2'd3),
         plain_row(16'h5001, OP_ED, OPC_LD_A_C, 8'h00, 2'd2),
         plain_row(16'h5002, OP_ED, ED_IN_R_C, 8'h00, 2'd3),
         plain_row(16'h5003, OP_DD, OP_LD_A_HL, 8'h80, 2'd3),
         plain_row(16'h5004, OP_FD, OPC_LD_IHL_N, 8'h12, 2'd3),
         plain_row(16'h5005, OPC_LD_A_NN, 8'hFF, 8'hFF, 2'd2),
         plain_row(16'h5006, OPC_CALL, 8'hFF, 8'hFF, 2'd3),
         plain_row(16'h5007, OPC_OUT_N_A, 8'hFF, 8'h00, 2'd1),
         plain_row(16'h5008, OPC_RST_38, 8'h00, 8'h00, 2'd3),
         plain_row(16'h5009, OPC_LD_A_B, 8'h00, 8'h00, 2'd1),
         plain_row(16'h500A, OP_HALT, 8'h00, 8'h00, 2'd3),
         plain_row(16'h500B, PAT_LD_R_N, 8'hFF, 8'h00, 2'd3),
         plain_row(16'hFFFE, OPC_LD_HL_NN, 8'hFF, 8'hFF, 2'd3)
      };

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) begin
         idle_gap(1'b0);
         send_beat(directed_rows[i]);
      end

      for (int n = 0; n < RandomBeats; n++) begin
         quiet = n >= 150 && n < 250;
         if (n == 300) begin
            start <= 1'b0;
            @(posedge clock);
            while (pending_decodes.size() != 0) @(posedge clock);
         end
         idle_gap(quiet);
         row = plain_row(16'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                         ($urandom_range(99) < 70) ? 2'd3 : 2'($urandom_range(2)));
         fld = 3'($urandom_range(7));
         case ($urandom_range(99)) inside
            [0:5]: row.op = OP_CB;
            [6:13]: begin
               row.op = OP_ED;
               if ($urandom_range(1) == 0) begin
                  case ($urandom_range(2))
                     0: row.b1 = ED_IN_R_C | {2'b00, fld, 3'b000};
                     1: row.b1 = ED_OUT_C_R | {2'b00, fld, 3'b000};
                     default: row.b1 = ED_LD_NN_RR | {2'b00, fld, 3'b000};
                  endcase
               end
            end
            [14:25]: begin
               row.op = $urandom_range(1) ? OP_DD : OP_FD;
               case ($urandom_range(5))
                  0: row.b1 = OP_LD_A_HL;
                  1: begin
                     case ($urandom_range(4))
                        0: row.b1 = OP_CB;
                        1: row.b1 = OP_DD;
                        2: row.b1 = OP_FD;
                        3: row.b1 = OP_ED;
                        default: row.b1 = OPC_LD_IHL_N;
                     endcase
                  end
                  2: row.b1 = {2'b01, fld, REG_HL_IND};
                  3: row.b1 = {2'b01, REG_HL_IND, fld};
                  4: row.b1 = {2'b10, fld, REG_HL_IND};
                  default: ;
               endcase
            end
            default: ;
         endcase
         send_beat(row);
      end

      start <= 1'b0;
      @(posedge clock);
      while (pending_decodes.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (fault_count == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

   initial begin
      #200_000;
      $display("end of test: mismatches");
      $finish;
   end

endmodule

// ----- files.f -----
rtl/z80ilc_pkg.sv
rtl/z80ilc_decode.sv
rtl/z80_instruction_length_classifier.sv
bench/testbench.sv
